[rtl/core/htp_pkg.sv]
// Shared types and register indexes for the heading turn PID controller.
package htp_pkg;

   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   localparam logic [CsrIndexWidth-1:0] CSR_KP                  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_KI                  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_KD                  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_INTEGRATE_ABOVE     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_SETTLE_TICKS        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_INTEGRAL_HOLD_TICKS = 3'd5;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [12:0] target_heading;
      logic [12:0] heading;
      logic [12:0] tolerance;
      logic [15:0] timeout_ticks;
   } htp_req_type;

   typedef struct packed {
      logic signed [15:0] drive;
      logic               done_res;
      logic               timed_out;
   } htp_rsp_type;

   typedef struct packed {
      logic [15:0] kp;
      logic [15:0] ki;
      logic [15:0] kd;
   } htp_gain_type;

   typedef struct packed {
      logic [12:0] integrate_above;
      logic [15:0] settle_ticks;
      logic [15:0] integral_hold_ticks;
   } htp_limit_type;

   typedef struct packed {
      logic signed [17:0] err;
      logic signed [18:0] deriv;
      logic [23:0]        integ;
      logic               spin;
      logic               zero_drive;
      logic               done;
      logic               tout;
   } htp_calc_type;

endpackage

[rtl/core/htp_state.sv]
// Turn state update: distance turned, error, conditional integral, timers and done.
module htp_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  item_valid,
   input  htp_pkg::htp_req_type  item,
   input  htp_pkg::htp_limit_type limits,
   output logic                  calc_valid_ff,
   output htp_pkg::htp_calc_type calc_ff
);

   localparam logic [12:0] FULL_TURN = 13'd5760;
   localparam logic [12:0] HALF_TURN = 13'd2880;
   localparam logic [12:0] WRAP_JUMP = 13'd4800;
   localparam logic [16:0] DIST_MAX  = 17'h1FFFF;
   localparam logic [23:0] INTEG_MAX = 24'hFFFFFF;
   localparam logic [15:0] TIMER_MAX = 16'hFFFF;

   function automatic logic [15:0] timer_inc(input logic [15:0] t);
      return (t == TIMER_MAX) ? TIMER_MAX : t + 16'd1;
   endfunction

   function automatic logic [12:0] abs_diff(input logic [12:0] a, input logic [12:0] b);
      logic signed [13:0] d;
      d = signed'({1'b0, a}) - signed'({1'b0, b});
      return d[13] ? 13'(-d) : d[12:0];
   endfunction

   logic [12:0]        prev_heading_ff, prev_heading_in;
   logic [16:0]        dist_ff, dist_in;
   logic [12:0]        total_ff, total_in;
   logic               spin_ff, spin_in;
   logic [23:0]        integ_ff, integ_in;
   logic signed [17:0] last_err_ff, last_err_in;
   logic [15:0]        itimer_ff, itimer_in;
   logic [15:0]        stimer_ff, stimer_in;
   logic [15:0]        etimer_ff, etimer_in;
   logic [12:0]        tol_ff, tol_in;
   logic [15:0]        tmo_ff, tmo_in;
   logic               active_ff, active_in;
   htp_pkg::htp_calc_type calc_in;

   logic [12:0]        delta_abs;
   logic [12:0]        delta;
   logic [17:0]        dist_sum;
   logic [16:0]        dist_new;
   logic signed [17:0] err;
   logic signed [17:0] tol_s;
   logic signed [17:0] above_s;
   logic [24:0]        integ_sum;
   logic [23:0]        integ_add;
   logic               err_le_tol;
   logic               err_ge_tol;
   logic [15:0]        itimer_mid;
   logic [15:0]        stimer_mid;
   logic               settled;
   logic               tout;
   logic               done;
   logic               spin_start;

   always_comb begin
      delta_abs = abs_diff(item.heading, prev_heading_ff);
      if (delta_abs > WRAP_JUMP) begin
         delta = (delta_abs >= FULL_TURN) ? delta_abs - FULL_TURN : FULL_TURN - delta_abs;
      end else begin
         delta = delta_abs;
      end
      dist_sum = {1'b0, dist_ff} + {5'd0, delta};
      dist_new = dist_sum[17] ? DIST_MAX : dist_sum[16:0];
      err      = signed'({5'd0, total_ff}) - signed'({1'b0, dist_new});
      tol_s    = signed'({5'd0, tol_ff});
      above_s  = signed'({5'd0, limits.integrate_above});
      integ_sum = {1'b0, integ_ff} + {12'd0, err[12:0]};
      if (err > above_s) begin
         integ_add = integ_sum[24] ? INTEG_MAX : integ_sum[23:0];
      end else begin
         integ_add = integ_ff;
      end
      err_le_tol = (err <= tol_s);
      err_ge_tol = (err >= tol_s);
      itimer_mid = itimer_ff;
      if (err_le_tol && (itimer_ff > limits.integral_hold_ticks)) begin
         integ_add = '0;
      end else if (err_ge_tol) begin
         itimer_mid = '0;
      end
      stimer_mid = err_ge_tol ? 16'd0 : stimer_ff;
      settled    = (stimer_mid >= limits.settle_ticks);
      tout       = (etimer_ff >= tmo_ff);
      done       = settled || tout;

      if (item.heading > HALF_TURN) begin
         spin_start = ({1'b0, item.heading} <= ({1'b0, item.target_heading} + {1'b0, FULL_TURN}));
      end else if (item.heading < HALF_TURN) begin
         spin_start = (item.heading < item.target_heading);
      end else begin
         spin_start = 1'b0;
      end
   end

   always_comb begin
      prev_heading_in = prev_heading_ff;
      dist_in         = dist_ff;
      total_in        = total_ff;
      spin_in         = spin_ff;
      integ_in        = integ_ff;
      last_err_in     = last_err_ff;
      itimer_in       = itimer_ff;
      stimer_in       = stimer_ff;
      etimer_in       = etimer_ff;
      tol_in          = tol_ff;
      tmo_in          = tmo_ff;
      active_in       = active_ff;
      calc_in.err        = err;
      calc_in.deriv      = 19'(err) - 19'(last_err_ff);
      calc_in.integ      = integ_add;
      calc_in.spin       = spin_ff;
      calc_in.zero_drive = 1'b1;
      calc_in.done       = 1'b0;
      calc_in.tout       = 1'b0;
      if (item_valid) begin
         if (item.func == htp_pkg::FUNC_START) begin
            prev_heading_in = item.heading;
            dist_in         = '0;
            total_in        = abs_diff(item.target_heading, item.heading);
            spin_in         = spin_start;
            integ_in        = '0;
            last_err_in     = '0;
            itimer_in       = '0;
            stimer_in       = '0;
            etimer_in       = '0;
            tol_in          = item.tolerance;
            tmo_in          = item.timeout_ticks;
            active_in       = 1'b1;
         end else if (active_ff) begin
            prev_heading_in = item.heading;
            dist_in         = dist_new;
            integ_in        = integ_add;
            last_err_in     = err;
            calc_in.done    = done;
            calc_in.tout    = tout;
            if (done) begin
               active_in  = 1'b0;
               itimer_in  = itimer_mid;
               stimer_in  = stimer_mid;
            end else begin
               calc_in.zero_drive = 1'b0;
               itimer_in  = timer_inc(itimer_mid);
               stimer_in  = timer_inc(stimer_mid);
               etimer_in  = timer_inc(etimer_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_heading_ff <= '0;
         dist_ff         <= '0;
         total_ff        <= '0;
         spin_ff         <= 1'b0;
         integ_ff        <= '0;
         last_err_ff     <= '0;
         itimer_ff       <= '0;
         stimer_ff       <= '0;
         etimer_ff       <= '0;
         tol_ff          <= '0;
         tmo_ff          <= '0;
         active_ff       <= 1'b0;
         calc_valid_ff   <= 1'b0;
      end else if (en) begin
         prev_heading_ff <= prev_heading_in;
         dist_ff         <= dist_in;
         total_ff        <= total_in;
         spin_ff         <= spin_in;
         integ_ff        <= integ_in;
         last_err_ff     <= last_err_in;
         itimer_ff       <= itimer_in;
         stimer_ff       <= stimer_in;
         etimer_ff       <= etimer_in;
         tol_ff          <= tol_in;
         tmo_ff          <= tmo_in;
         active_ff       <= active_in;
         calc_valid_ff   <= item_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         calc_ff <= calc_in;
      end
   end

endmodule

[rtl/core/htp_drive.sv]
// Drive pipeline: gain products, sum, rounding, direction and saturation.
module htp_drive (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  calc_valid,
   input  htp_pkg::htp_calc_type calc,
   input  htp_pkg::htp_gain_type gains,
   output logic                  rsp_valid_ff,
   output htp_pkg::htp_rsp_type  rsp_ff
);

   localparam logic [33:0] POS_LIMIT = 34'd32767;
   localparam logic [33:0] NEG_LIMIT = 34'd32768;

   logic signed [16:0] kp_s;
   logic signed [16:0] kd_s;

   logic               prod_valid_ff;
   logic signed [34:0] prod_p_ff, prod_p_in;
   logic [39:0]        prod_i_ff, prod_i_in;
   logic signed [35:0] prod_d_ff, prod_d_in;
   logic               prod_spin_ff;
   logic               prod_zero_ff;
   logic               prod_done_ff;
   logic               prod_tout_ff;

   logic               sum_valid_ff;
   logic signed [41:0] sum_ff, sum_in;
   logic               sum_spin_ff;
   logic               sum_zero_ff;
   logic               sum_done_ff;
   logic               sum_tout_ff;

   logic               neg;
   logic [41:0]        mag;
   logic [33:0]        q;
   logic [15:0]        q_low;
   logic               flip;
   htp_pkg::htp_rsp_type rsp_in;

   always_comb begin
      kp_s      = signed'({1'b0, gains.kp});
      kd_s      = signed'({1'b0, gains.kd});
      prod_p_in = calc.err * kp_s;
      prod_i_in = calc.integ * gains.ki;
      prod_d_in = calc.deriv * kd_s;
      sum_in    = 42'(prod_p_ff) + signed'({2'b00, prod_i_ff}) + 42'(prod_d_ff);
   end

   always_comb begin
      neg   = sum_ff[41];
      mag   = neg ? 42'(-sum_ff) : 42'(sum_ff);
      q     = 34'((mag + 42'd128) >> 8);
      q_low = q[15:0];
      flip  = neg ^ sum_spin_ff;
      rsp_in.done_res  = sum_done_ff;
      rsp_in.timed_out = sum_tout_ff;
      if (sum_zero_ff) begin
         rsp_in.drive = '0;
      end else if (flip) begin
         rsp_in.drive = (q > NEG_LIMIT) ? 16'sh8000 : signed'(16'(-q_low));
      end else begin
         rsp_in.drive = (q > POS_LIMIT) ? 16'sh7FFF : signed'(q_low);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (en) begin
         prod_valid_ff <= calc_valid;
         sum_valid_ff  <= prod_valid_ff;
         rsp_valid_ff  <= sum_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_p_ff    <= prod_p_in;
         prod_i_ff    <= prod_i_in;
         prod_d_ff    <= prod_d_in;
         prod_spin_ff <= calc.spin;
         prod_zero_ff <= calc.zero_drive;
         prod_done_ff <= calc.done;
         prod_tout_ff <= calc.tout;
         sum_ff       <= sum_in;
         sum_spin_ff  <= prod_spin_ff;
         sum_zero_ff  <= prod_zero_ff;
         sum_done_ff  <= prod_done_ff;
         sum_tout_ff  <= prod_tout_ff;
         rsp_ff       <= rsp_in;
      end
   end

endmodule

[rtl/core/heading_turn_pid.sv]
// Top level of the heading turn PID controller: registers, input stage and pipeline.
//
// Request items arrive on req_valid/req_ready with an htp_req_type payload.
// func start latches target, tolerance and timeout; func tick runs one
// control update on the measured heading. Every item gives one response
// item on rsp_valid/rsp_ready: drive, done_res and timed_out.
// Gains and limits are written through csr_we/csr_index/csr_wdata; the
// user must write them only while no item is in flight, which the block
// itself does not enforce; writes to unknown indexes are dropped.
// The accepting edge loads the input register, then state update, gain
// products, sum, and rounding with saturation into the response register
// are each registered in turn. Throughput is one item per cycle while
// responses are taken; the state update stage closes its loop within itself.
// When rsp_ready is low with a response waiting, the whole pipeline holds
// and req_ready drops; it resumes as soon as the response is taken.
// Synchronous reset empties the pipeline, sets the registers to their
// defaults and leaves the controller idle.
module heading_turn_pid (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  htp_pkg::htp_req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output htp_pkg::htp_rsp_type                   rsp_data,
   input  logic                                   csr_we,
   input  logic [htp_pkg::CsrIndexWidth-1:0]      csr_index,
   input  logic [htp_pkg::CsrDataWidth-1:0]       csr_wdata
);

   htp_pkg::htp_gain_type  gains_ff;
   htp_pkg::htp_limit_type limits_ff;
   htp_pkg::htp_req_type   item_ff;
   htp_pkg::htp_calc_type  calc;
   logic                   item_valid_ff;
   logic                   calc_valid;
   logic                   en;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp                   <= 16'd538;
         gains_ff.ki                   <= 16'd0;
         gains_ff.kd                   <= 16'd26;
         limits_ff.integrate_above     <= 13'd480;
         limits_ff.settle_ticks        <= 16'd1;
         limits_ff.integral_hold_ticks <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            htp_pkg::CSR_KP: begin
               gains_ff.kp <= csr_wdata;
            end
            htp_pkg::CSR_KI: begin
               gains_ff.ki <= csr_wdata;
            end
            htp_pkg::CSR_KD: begin
               gains_ff.kd <= csr_wdata;
            end
            htp_pkg::CSR_INTEGRATE_ABOVE: begin
               limits_ff.integrate_above <= csr_wdata[12:0];
            end
            htp_pkg::CSR_SETTLE_TICKS: begin
               limits_ff.settle_ticks <= csr_wdata;
            end
            htp_pkg::CSR_INTEGRAL_HOLD_TICKS: begin
               limits_ff.integral_hold_ticks <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (en) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= req_data;
      end
   end

   htp_state u_state (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .item_valid    (item_valid_ff),
      .item          (item_ff),
      .limits        (limits_ff),
      .calc_valid_ff (calc_valid),
      .calc_ff       (calc)
   );

   htp_drive u_drive (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .calc_valid   (calc_valid),
      .calc         (calc),
      .gains        (gains_ff),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_data)
   );

endmodule
